@@ rtl/multichannel_one_euro_filter_top_assert.svh @@
// Assertion macros shared by the filter RTL.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef MULTICHANNEL_ONE_EURO_FILTER_TOP_ASSERT_SVH
`define MULTICHANNEL_ONE_EURO_FILTER_TOP_ASSERT_SVH

// property holds at every edge out of reset
`define OME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition never true out of reset
`define OME_ASSERT_NEVER(label, cond, msg) \
  `OME_ASSERT(label, !(cond), msg)

`endif

@@ rtl/ome_pkg.sv @@
`default_nettype none

package ome_pkg;

  // sequencer states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_RMUL,
    S_RGO,
    S_RDIV,
    S_AM1,
    S_AM2,
    S_AM3,
    S_NORM,
    S_AGO,
    S_ADIV,
    S_SMUL,
    S_SADD,
    S_CUT1,
    S_CUT2,
    S_DONE
  } ome_state_e;

  // register indexes (word address)
  localparam logic [1:0] REG_MIN_CUTOFF   = 2'd0;
  localparam logic [1:0] REG_SPEED_GAIN   = 2'd1;
  localparam logic [1:0] REG_DERIV_CUTOFF = 2'd2;

  localparam logic [15:0] MIN_CUTOFF_RST   = 16'd256;
  localparam logic [15:0] SPEED_GAIN_RST   = 16'd0;
  localparam logic [15:0] DERIV_CUTOFF_RST = 16'd256;

  // arithmetic constants
  localparam logic [14:0] TWO_PI_Q12 = 15'd25736;
  localparam logic [63:0] ALPHA_DEN  = 64'd1048576000000;
  localparam logic [19:0] US_PER_S   = 20'd1000000;
  localparam int unsigned NORM_BIT   = 47;

  // shared divider widths
  localparam int unsigned DIV_W = 64;
  localparam int unsigned DSR_W = 48;

  // one channel's stored state
  typedef struct packed {
    logic [31:0] last_filtered;
    logic [31:0] last_derivative;
    logic [31:0] last_time;
  } ome_entry_t;

  // state memory control
  typedef struct packed {
    logic rd;
    logic wr;
  } ome_mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/multichannel_one_euro_filter_top.sv @@
// Multichannel one-euro filter.
// Input channel (in_valid_i/in_ready_o): channel, Q16.16 sample, timestamp in us.
// Output channel (out_valid_o/out_ready_i): filtered value, channel echo, stale flag.
// One result beat per input beat, in order. APB port holds the three Q8.8 registers.
// Per-channel state sits in a registered-read memory; one item is worked at a time.
// Sequence: a first sample, zero interval or out-of-range channel passes from the
// evaluate state straight to the done state, which loads out_valid_o. A normal
// update runs the shared 64-step divider three times (rate, then two smoothing
// factors), each smoothing division after normalize shifts of its operands.
// in_ready_o is high only in the idle state; the next beat is taken while a result
// still waits in the output register.
// A stalled receiver holds the result in the output register; the block finishes
// the next item and then waits until that register frees.
// After reset a sweep clears the seen flag of every channel; no input beat is
// taken during it, register writes are.
`default_nettype none
`include "multichannel_one_euro_filter_top_assert.svh"

module multichannel_one_euro_filter_top #(
  parameter int unsigned CHANNELS  = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         channel_i,
  input  logic signed [31:0] sample_value_i,
  input  logic [31:0]        timestamp_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] filtered_value_o,
  output logic [7:0]         channel_echo_o,
  output logic               stale_interval_o
);
  import ome_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // registers
  logic [15:0] min_cut_q, speed_q, dcut_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cut_q <= MIN_CUTOFF_RST;
      speed_q   <= SPEED_GAIN_RST;
      dcut_q    <= DERIV_CUTOFF_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MIN_CUTOFF:   min_cut_q <= pwdata[15:0];
        REG_SPEED_GAIN:   speed_q   <= pwdata[15:0];
        REG_DERIV_CUTOFF: dcut_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN_CUTOFF:   prdata = {16'd0, min_cut_q};
      REG_SPEED_GAIN:   prdata = {16'd0, speed_q};
      REG_DERIV_CUTOFF: prdata = {16'd0, dcut_q};
      default:          prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // sequencer and datapath registers
  ome_state_e     st_q, st_d;
  logic [7:0]     ch_q;
  logic [31:0]    x_q, t_q, dt_q, prev_q, dprev_q;
  logic [31:0]    tgt_q, prv_q, dxh_q, res_q;
  logic [15:0]    fc_q, alpha_q;
  logic [30:0]    p1_q;
  logic [62:0]    n_q;
  logic [63:0]    s_q;
  logic [52:0]    prod_q;
  logic           neg_q, phase_q, stale_q;
  logic           out_valid_q;
  logic [31:0]    out_val_q;
  logic [7:0]     out_ch_q;
  logic           out_stale_q;

  // memory and divider
  ome_mem_ctl_t   mem_ctl;
  logic [AW-1:0]  mem_addr;
  ome_entry_t     mem_wdata, rd_entry;
  logic           rd_seen, clr_busy;
  logic           div_start, div_busy, div_done;
  logic [63:0]    div_dividend, div_quo;
  logic [47:0]    div_divisor;

  ome_state_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (mem_ctl),
    .addr_i       (mem_addr),
    .wdata_i      (mem_wdata),
    .rd_seen_o    (rd_seen),
    .rd_entry_o   (rd_entry),
    .clear_busy_o (clr_busy)
  );

  ome_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // evaluation of the read entry
  logic        in_acc, ch_in_range, norm_more, out_load;
  logic [31:0] dt_c;

  assign in_acc      = in_valid_i && in_ready_o;
  assign ch_in_range = (32'(ch_q) < 32'(CHANNELS));
  assign dt_c        = t_q - rd_entry.last_time;
  assign norm_more   = |s_q[63:NORM_BIT];
  assign out_load    = (st_q == S_DONE) && (!out_valid_q || out_ready_i);

  // rate: x - prev magnitude
  logic signed [32:0] rdiff;
  logic [32:0]        rmag;
  assign rdiff = {x_q[31], x_q} - {prev_q[31], prev_q};
  assign rmag  = rdiff[32] ? 33'(-rdiff) : 33'(rdiff);

  // rate quotient saturation
  logic [31:0] rq_sat, dx_c;
  always_comb begin
    if (neg_q) begin
      rq_sat = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : div_quo[31:0];
      dx_c   = 32'(-rq_sat);
    end else begin
      rq_sat = (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
      dx_c   = rq_sat;
    end
  end

  // smoothing step
  logic signed [32:0] sdiff;
  logic [32:0]        smag;
  logic [49:0]        sround;
  logic [33:0]        sstep, ysum;
  logic [31:0]        y_c;
  assign sdiff  = {tgt_q[31], tgt_q} - {prv_q[31], prv_q};
  assign smag   = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
  assign sround = {1'b0, prod_q[48:0]} + 50'd32768;
  assign sstep  = sround[49:16];
  assign ysum   = neg_q ? ({{2{prv_q[31]}}, prv_q} - sstep)
                        : ({{2{prv_q[31]}}, prv_q} + sstep);
  assign y_c    = ysum[31:0];

  // cutoff from derivative magnitude
  logic [31:0] dmag;
  logic [47:0] cshift;
  logic [48:0] csum;
  logic [15:0] fc_c;
  assign dmag   = dxh_q[31] ? 32'(-dxh_q) : dxh_q;
  assign cshift = prod_q[47:0] >> FRAC_BITS;
  assign csum   = {33'd0, min_cut_q} + {1'b0, cshift};
  assign fc_c   = (csum > 49'h0FFFF) ? 16'hFFFF : csum[15:0];

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_CLEAR: if (!clr_busy) st_d = S_IDLE;
      S_IDLE:  if (in_valid_i) st_d = S_EVAL;
      S_EVAL: begin
        if (!ch_in_range || !rd_seen || (dt_c == 32'd0)) st_d = S_DONE;
        else st_d = S_RMUL;
      end
      S_RMUL:  st_d = S_RGO;
      S_RGO:   st_d = S_RDIV;
      S_RDIV:  if (div_done) st_d = S_AM1;
      S_AM1:   st_d = S_AM2;
      S_AM2:   st_d = S_AM3;
      S_AM3:   st_d = S_NORM;
      S_NORM:  if (!norm_more) st_d = S_AGO;
      S_AGO:   st_d = S_ADIV;
      S_ADIV:  if (div_done) st_d = S_SMUL;
      S_SMUL:  st_d = S_SADD;
      S_SADD:  st_d = phase_q ? S_DONE : S_CUT1;
      S_CUT1:  st_d = S_CUT2;
      S_CUT2:  st_d = S_AM1;
      S_DONE:  if (out_load) st_d = S_IDLE;
      default: st_d = S_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o   = (st_q == S_IDLE);
    mem_ctl.rd   = in_valid_i && (st_q == S_IDLE);
    mem_ctl.wr   = ((st_q == S_EVAL) && ch_in_range && !rd_seen) ||
                   ((st_q == S_SADD) && phase_q);
    mem_addr     = (st_q == S_IDLE) ? AW'(channel_i) : AW'(ch_q);
    mem_wdata    = (st_q == S_EVAL) ? {x_q, 32'd0, t_q} : {y_c, dxh_q, t_q};
    div_start    = (st_q == S_RGO) || (st_q == S_AGO);
    if (st_q == S_RGO) begin
      div_dividend = {11'd0, prod_q};
      div_divisor  = {16'd0, dt_q};
    end else begin
      div_dividend = {1'b0, n_q[46:0], 16'd0};
      div_divisor  = s_q[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR;
    end else begin
      st_q <= st_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        ch_q <= channel_i;
        x_q  <= sample_value_i;
        t_q  <= timestamp_us_i;
      end
      S_EVAL: begin
        prev_q  <= rd_entry.last_filtered;
        dprev_q <= rd_entry.last_derivative;
        dt_q    <= dt_c;
        // zero interval returns the stored value
        stale_q <= ch_in_range && rd_seen && (dt_c == 32'd0);
        res_q   <= (ch_in_range && rd_seen && (dt_c == 32'd0)) ?
                   rd_entry.last_filtered : x_q;
      end
      S_RMUL: begin
        neg_q  <= rdiff[32];
        prod_q <= 53'(rmag) * 53'(US_PER_S);
      end
      S_RDIV: begin
        if (div_done) begin
          tgt_q   <= dx_c;
          prv_q   <= dprev_q;
          fc_q    <= dcut_q;
          phase_q <= 1'b0;
        end
      end
      S_AM1: p1_q <= 31'(fc_q) * 31'(TWO_PI_Q12);
      S_AM2: n_q  <= 63'(p1_q) * 63'(dt_q);
      S_AM3: s_q  <= {1'b0, n_q} + ALPHA_DEN;
      S_NORM: begin
        if (norm_more) begin
          n_q <= n_q >> 1;
          s_q <= s_q >> 1;
        end
      end
      S_ADIV: if (div_done) alpha_q <= div_quo[15:0];
      S_SMUL: begin
        neg_q  <= sdiff[32];
        prod_q <= 53'(smag) * 53'(alpha_q);
      end
      S_SADD: begin
        if (phase_q) res_q <= y_c;
        else dxh_q <= y_c;
      end
      S_CUT1: prod_q <= 53'(speed_q) * 53'(dmag);
      S_CUT2: begin
        fc_q    <= fc_c;
        tgt_q   <= x_q;
        prv_q   <= prev_q;
        phase_q <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q   <= res_q;
      out_ch_q    <= ch_q;
      out_stale_q <= stale_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_val_q;
  assign channel_echo_o   = out_ch_q;
  assign stale_interval_o = out_stale_q;

  // checks
  `OME_ASSERT(a_idle_div_free, in_ready_o |-> !div_busy, "beat taken while divider busy")
  `OME_ASSERT(a_eval_after_acc, st_q == S_EVAL |-> $past(in_acc), "evaluate without accept")
  `OME_ASSERT_NEVER(a_no_wr_in_clear, mem_ctl.wr && clr_busy, "state write during clear")

endmodule

`default_nettype wire

@@ rtl/ome_div.sv @@
`default_nettype none

module ome_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ome_pkg::DIV_W-1:0] dividend_i,
  input  logic [ome_pkg::DSR_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [ome_pkg::DIV_W-1:0] quotient_o
);
  import ome_pkg::*;

  localparam int unsigned CW = $clog2(DIV_W);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [DSR_W-1:0]  rem_q, dsr_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DSR_W:0]    rem_sh, rem_sub;
  logic              ge;

  // one restoring step per cycle
  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = (rem_sh >= {1'b0, dsr_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ rtl/ome_state_mem.sv @@
`default_nettype none

module ome_state_mem #(
  parameter int unsigned CHANNELS = 256,
  parameter int unsigned AW       = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ome_pkg::ome_mem_ctl_t ctl_i,
  input  logic [AW-1:0]        addr_i,
  input  ome_pkg::ome_entry_t  wdata_i,
  output logic                 rd_seen_o,
  output ome_pkg::ome_entry_t  rd_entry_o,
  output logic                 clear_busy_o
);
  import ome_pkg::*;

  ome_entry_t     entry_mem [CHANNELS];
  logic           seen_mem  [CHANNELS];
  logic [AW:0]    clr_cnt_q;
  logic           clr_busy;

  assign clr_busy = (clr_cnt_q != (AW+1)'(CHANNELS));

  // clearing sweep of the seen flags after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // seen flag memory
  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      seen_mem[clr_cnt_q[AW-1:0]] <= 1'b0;
    end else if (ctl_i.wr) begin
      seen_mem[addr_i] <= 1'b1;
    end
    if (ctl_i.rd) begin
      rd_seen_o <= seen_mem[addr_i];
    end
  end

  // value memory, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      entry_mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rd_entry_o <= entry_mem[addr_i];
    end
  end

  assign clear_busy_o = clr_busy;

endmodule

`default_nettype wire
